@@ src/rgsr_pkg.sv @@
// Shared types and constants for the run-length glyph span rasterizer.
// Holds the beat payload structs, the configuration struct and the decode phases.
// No dependencies.
package rgsr_pkg;

  localparam int COORD_BITS = 16;
  localparam int EXT_BITS   = COORD_BITS + 1;
  localparam int CLIP_BITS  = 11;
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 11;

  localparam logic [CFG_IDX_BITS-1:0] CFG_PEN_COLOR   = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_CLIP_LEFT   = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_CLIP_RIGHT  = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_CLIP_TOP    = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] CFG_CLIP_BOTTOM = 3'd4;

  localparam logic [CLIP_BITS-1:0] CLIP_RIGHT_RESET  = 11'd640;
  localparam logic [CLIP_BITS-1:0] CLIP_BOTTOM_RESET = 11'd480;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_WIDTH,
    PH_HEIGHT,
    PH_XOFF,
    PH_YOFF,
    PH_COUNT,
    PH_SKIP,
    PH_RUN
  } phase_t;

  typedef struct packed {
    logic              glyph_start;
    logic signed [11:0] origin_x;
    logic signed [11:0] origin_y;
    logic [7:0]        glyph_byte;
  } item_t;

  typedef struct packed {
    logic                 span_valid;
    logic [CLIP_BITS-1:0] span_x;
    logic [CLIP_BITS-1:0] span_y;
    logic [7:0]           span_len;
    logic [7:0]           span_color;
    logic                 glyph_done;
    logic [7:0]           glyph_width;
  } span_t;

  typedef struct packed {
    logic [7:0]           pen_color;
    logic [CLIP_BITS-1:0] clip_left;
    logic [CLIP_BITS-1:0] clip_right;
    logic [CLIP_BITS-1:0] clip_top;
    logic [CLIP_BITS-1:0] clip_bottom;
  } cfg_t;

endpackage

@@ src/rgsr_cfg_regs.sv @@
// Configuration register bank: pen color and clip rectangle.
// Depends on rgsr_pkg.
module rgsr_cfg_regs (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [rgsr_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [rgsr_pkg::CFG_DATA_BITS-1:0]  cfg_wdata,
  output rgsr_pkg::cfg_t                      cfg
);

  rgsr_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pen_color   <= '0;
      cfg_r.clip_left   <= '0;
      cfg_r.clip_right  <= rgsr_pkg::CLIP_RIGHT_RESET;
      cfg_r.clip_top    <= '0;
      cfg_r.clip_bottom <= rgsr_pkg::CLIP_BOTTOM_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        rgsr_pkg::CFG_PEN_COLOR:   cfg_r.pen_color   <= cfg_wdata[7:0];
        rgsr_pkg::CFG_CLIP_LEFT:   cfg_r.clip_left   <= cfg_wdata;
        rgsr_pkg::CFG_CLIP_RIGHT:  cfg_r.clip_right  <= cfg_wdata;
        rgsr_pkg::CFG_CLIP_TOP:    cfg_r.clip_top    <= cfg_wdata;
        rgsr_pkg::CFG_CLIP_BOTTOM: cfg_r.clip_bottom <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

@@ src/rgsr_span_clip.sv @@
// Clips one run at the pen position against the configured rectangle.
// Purely combinational; depends on rgsr_pkg.
module rgsr_span_clip (
  input  logic signed [rgsr_pkg::COORD_BITS-1:0] cursor_x,
  input  logic signed [rgsr_pkg::COORD_BITS-1:0] cursor_y,
  input  logic [7:0]                             run_len,
  input  rgsr_pkg::cfg_t                         cfg,
  output logic                                   span_valid,
  output logic [rgsr_pkg::CLIP_BITS-1:0]         span_x,
  output logic [rgsr_pkg::CLIP_BITS-1:0]         span_y,
  output logic [7:0]                             span_len,
  output logic [7:0]                             span_color
);

  localparam int EB = rgsr_pkg::EXT_BITS;
  localparam int CB = rgsr_pkg::CLIP_BITS;

  logic signed [EB-1:0] x_ext, y_ext, run_ext, stop_raw;
  logic signed [EB-1:0] left_ext, right_ext, top_ext, bottom_ext;
  logic signed [EB-1:0] start, stop, diff;
  logic                 visible;

  // The run's own end column is one bit wider so it never wraps.
  assign x_ext      = {cursor_x[rgsr_pkg::COORD_BITS-1], cursor_x};
  assign y_ext      = {cursor_y[rgsr_pkg::COORD_BITS-1], cursor_y};
  assign run_ext    = {{(EB-8){1'b0}}, run_len};
  assign left_ext   = {{(EB-CB){1'b0}}, cfg.clip_left};
  assign right_ext  = {{(EB-CB){1'b0}}, cfg.clip_right};
  assign top_ext    = {{(EB-CB){1'b0}}, cfg.clip_top};
  assign bottom_ext = {{(EB-CB){1'b0}}, cfg.clip_bottom};
  assign stop_raw   = x_ext + run_ext;

  always_comb begin
    start   = (x_ext < left_ext) ? left_ext : x_ext;
    stop    = (stop_raw > right_ext) ? right_ext : stop_raw;
    diff    = stop - start;
    visible = (start < stop) && (y_ext >= top_ext) && (y_ext < bottom_ext);
  end

  assign span_valid = visible;
  assign span_x     = visible ? start[CB-1:0] : '0;
  assign span_y     = visible ? cursor_y[CB-1:0] : '0;
  assign span_len   = visible ? diff[7:0] : '0;
  assign span_color = visible ? cfg.pen_color : '0;

endmodule

@@ src/rgsr_decoder.sv @@
// Glyph record decoder: phase sequencer, pen cursors and row/entry counters.
// Computes the result of the current beat; depends on rgsr_pkg and rgsr_span_clip.
module rgsr_decoder (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            fire,
  input  rgsr_pkg::item_t item,
  input  rgsr_pkg::cfg_t  cfg,
  output rgsr_pkg::span_t result
);

  localparam int CB = rgsr_pkg::COORD_BITS;

  rgsr_pkg::phase_t phase_r, phase_nxt;
  logic signed [CB-1:0] cursor_x_r, cursor_x_nxt;
  logic signed [CB-1:0] cursor_y_r, cursor_y_nxt;
  logic signed [CB-1:0] row_start_x_r, row_start_x_nxt;
  logic [7:0] rows_left_r, rows_left_nxt;
  logic [7:0] entries_left_r, entries_left_nxt;
  logic [7:0] width_seen_r, width_seen_nxt;

  logic signed [CB-1:0] byte_ext, x_plus_byte, y_plus_byte, y_plus_one;
  logic [7:0] entries_dec, rows_dec;
  logic       is_entry, row_end, glyph_end;
  logic       clip_valid;
  logic [rgsr_pkg::CLIP_BITS-1:0] clip_x, clip_y;
  logic [7:0] clip_len, clip_color;

  assign byte_ext    = {{(CB-8){1'b0}}, item.glyph_byte};
  assign x_plus_byte = cursor_x_r + byte_ext;
  assign y_plus_byte = cursor_y_r + byte_ext;
  assign y_plus_one  = cursor_y_r + {{(CB-1){1'b0}}, 1'b1};
  assign entries_dec = entries_left_r - 8'd1;
  assign rows_dec    = rows_left_r - 8'd1;

  // Skip and run bytes both consume a row entry; the last one closes the row.
  assign is_entry  = !item.glyph_start && (phase_r == rgsr_pkg::PH_SKIP ||
                                           phase_r == rgsr_pkg::PH_RUN);
  assign row_end   = is_entry && (entries_dec == 8'd0);
  assign glyph_end = row_end && (rows_dec == 8'd0);

  rgsr_span_clip u_clip (
    .cursor_x   (cursor_x_r),
    .cursor_y   (cursor_y_r),
    .run_len    (item.glyph_byte),
    .cfg        (cfg),
    .span_valid (clip_valid),
    .span_x     (clip_x),
    .span_y     (clip_y),
    .span_len   (clip_len),
    .span_color (clip_color)
  );

  // Next phase.
  always_comb begin
    phase_nxt = phase_r;
    if (item.glyph_start) begin
      phase_nxt = rgsr_pkg::PH_WIDTH;
    end else begin
      case (phase_r)
        rgsr_pkg::PH_IDLE:   phase_nxt = rgsr_pkg::PH_IDLE;
        rgsr_pkg::PH_WIDTH:  phase_nxt = rgsr_pkg::PH_HEIGHT;
        rgsr_pkg::PH_HEIGHT: phase_nxt = rgsr_pkg::PH_XOFF;
        rgsr_pkg::PH_XOFF:   phase_nxt = rgsr_pkg::PH_YOFF;
        rgsr_pkg::PH_YOFF:   phase_nxt = rgsr_pkg::PH_COUNT;
        rgsr_pkg::PH_COUNT:  phase_nxt = rgsr_pkg::PH_SKIP;
        rgsr_pkg::PH_SKIP, rgsr_pkg::PH_RUN: begin
          if (glyph_end) begin
            phase_nxt = rgsr_pkg::PH_IDLE;
          end else if (row_end) begin
            phase_nxt = rgsr_pkg::PH_COUNT;
          end else if (phase_r == rgsr_pkg::PH_SKIP) begin
            phase_nxt = rgsr_pkg::PH_RUN;
          end else begin
            phase_nxt = rgsr_pkg::PH_SKIP;
          end
        end
        default: phase_nxt = rgsr_pkg::PH_IDLE;
      endcase
    end
  end

  // Next cursor and counter values.
  always_comb begin
    cursor_x_nxt     = cursor_x_r;
    cursor_y_nxt     = cursor_y_r;
    row_start_x_nxt  = row_start_x_r;
    rows_left_nxt    = rows_left_r;
    entries_left_nxt = entries_left_r;
    width_seen_nxt   = width_seen_r;
    if (item.glyph_start) begin
      cursor_x_nxt     = {{(CB-12){item.origin_x[11]}}, item.origin_x};
      cursor_y_nxt     = {{(CB-12){item.origin_y[11]}}, item.origin_y};
      row_start_x_nxt  = {{(CB-12){item.origin_x[11]}}, item.origin_x};
      rows_left_nxt    = '0;
      entries_left_nxt = '0;
      width_seen_nxt   = '0;
    end else begin
      case (phase_r)
        rgsr_pkg::PH_WIDTH:  width_seen_nxt = item.glyph_byte;
        rgsr_pkg::PH_HEIGHT: rows_left_nxt  = item.glyph_byte;
        rgsr_pkg::PH_XOFF: begin
          cursor_x_nxt    = x_plus_byte;
          row_start_x_nxt = x_plus_byte;
        end
        rgsr_pkg::PH_YOFF:   cursor_y_nxt     = y_plus_byte;
        rgsr_pkg::PH_COUNT:  entries_left_nxt = item.glyph_byte;
        rgsr_pkg::PH_SKIP, rgsr_pkg::PH_RUN: begin
          entries_left_nxt = entries_dec;
          if (row_end) begin
            cursor_x_nxt  = row_start_x_r;
            cursor_y_nxt  = y_plus_one;
            rows_left_nxt = rows_dec;
          end else begin
            cursor_x_nxt = x_plus_byte;
          end
        end
        default: ;
      endcase
    end
  end

  // Result of the current beat.
  always_comb begin
    result             = '0;
    result.glyph_done  = glyph_end;
    result.glyph_width = width_seen_nxt;
    if (!item.glyph_start && phase_r == rgsr_pkg::PH_RUN) begin
      result.span_valid = clip_valid;
      result.span_x     = clip_x;
      result.span_y     = clip_y;
      result.span_len   = clip_len;
      result.span_color = clip_color;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= rgsr_pkg::PH_IDLE;
      cursor_x_r     <= '0;
      cursor_y_r     <= '0;
      row_start_x_r  <= '0;
      rows_left_r    <= '0;
      entries_left_r <= '0;
      width_seen_r   <= '0;
    end else if (fire) begin
      phase_r        <= phase_nxt;
      cursor_x_r     <= cursor_x_nxt;
      cursor_y_r     <= cursor_y_nxt;
      row_start_x_r  <= row_start_x_nxt;
      rows_left_r    <= rows_left_nxt;
      entries_left_r <= entries_left_nxt;
      width_seen_r   <= width_seen_nxt;
    end
  end

endmodule

@@ src/rle_glyph_span_rasterizer_unit.sv @@
// Run-length glyph span rasterizer: one glyph byte in per beat, one span result out per beat.
// A start beat loads the pen origin; header, row counts, skip and run bytes follow. Each
// beat is registered at the input, decoded in a single combinational pass and registered
// at the output, so one beat is taken every cycle unless the output stalls. An accepted
// beat's result enters the output register once it frees up. While a result is stalled,
// one more beat can still enter the input register; only then does the input stall.
// Configuration writes are taken at any time but must only change while the unit is idle.
// Depends on rgsr_pkg, rgsr_cfg_regs, rgsr_span_clip and rgsr_decoder.
module rle_glyph_span_rasterizer_unit (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  rgsr_pkg::item_t                    in_data,
  output logic                               out_valid,
  input  logic                               out_stall,
  output rgsr_pkg::span_t                    out_data,
  input  logic                               cfg_we,
  input  logic [rgsr_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [rgsr_pkg::CFG_DATA_BITS-1:0] cfg_wdata
);

  rgsr_pkg::cfg_t  cfg;
  rgsr_pkg::item_t s1_item_r;
  rgsr_pkg::span_t out_data_r, result;
  logic s1_valid_r, out_valid_r;
  logic advance, fire, in_accept;

  // The output register moves whenever it is empty or being drained.
  assign advance   = !out_valid_r || !out_stall;
  assign fire      = s1_valid_r && advance;
  assign in_stall  = s1_valid_r && !advance;
  assign in_accept = in_valid && !in_stall;

  rgsr_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  rgsr_decoder u_dec (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire   (fire),
    .item   (s1_item_r),
    .cfg    (cfg),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_accept) begin
      s1_valid_r <= 1'b1;
    end else if (fire) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_item_r <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_data_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// Testbench for rle_glyph_span_rasterizer_unit: directed glyphs, clip settings, wrapping
// counters and random glyph streams, each span beat checked against an in-bench decoder.
// Depends on rgsr_pkg and rle_glyph_span_rasterizer_unit.
module tb;

  localparam int ITEMS_PER_PHASE = 25;
  localparam int RANDOM_PHASES = 4;

  logic                               clk = 1'b0;
  logic                               rst_n;
  logic                               in_valid;
  logic                               in_stall;
  rgsr_pkg::item_t                    in_data;
  logic                               out_valid;
  logic                               out_stall;
  rgsr_pkg::span_t                    out_data;
  logic                               cfg_we;
  logic [rgsr_pkg::CFG_IDX_BITS-1:0]  cfg_index;
  logic [rgsr_pkg::CFG_DATA_BITS-1:0] cfg_wdata;

  bit              idle_on = 1'b1;
  int              errors = 0;
  rgsr_pkg::span_t spans_due[$];

  // Decoder state mirrored in the bench.
  rgsr_pkg::cfg_t                         clip_cfg;
  rgsr_pkg::phase_t                       dec_phase;
  logic signed [rgsr_pkg::COORD_BITS-1:0] pen_x;
  logic signed [rgsr_pkg::COORD_BITS-1:0] pen_y;
  logic signed [rgsr_pkg::COORD_BITS-1:0] row_x;
  logic [7:0]                             rows_left;
  logic [7:0]                             entries_left;
  logic [7:0]                             width_seen;

  rle_glyph_span_rasterizer_unit i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void reset_decoder();
    clip_cfg.pen_color   = '0;
    clip_cfg.clip_left   = '0;
    clip_cfg.clip_right  = rgsr_pkg::CLIP_RIGHT_RESET;
    clip_cfg.clip_top    = '0;
    clip_cfg.clip_bottom = rgsr_pkg::CLIP_BOTTOM_RESET;
    dec_phase    = rgsr_pkg::PH_IDLE;
    pen_x        = '0;
    pen_y        = '0;
    row_x        = '0;
    rows_left    = '0;
    entries_left = '0;
    width_seen   = '0;
  endfunction

  function automatic void apply_cfg(logic [rgsr_pkg::CFG_IDX_BITS-1:0] idx,
                                    logic [rgsr_pkg::CFG_DATA_BITS-1:0] data);
    case (idx)
      rgsr_pkg::CFG_PEN_COLOR:   clip_cfg.pen_color = data[7:0];
      rgsr_pkg::CFG_CLIP_LEFT:   clip_cfg.clip_left = data;
      rgsr_pkg::CFG_CLIP_RIGHT:  clip_cfg.clip_right = data;
      rgsr_pkg::CFG_CLIP_TOP:    clip_cfg.clip_top = data;
      rgsr_pkg::CFG_CLIP_BOTTOM: clip_cfg.clip_bottom = data;
      default: ;
    endcase
  endfunction

  // Consumes one row entry; returns 1 when the last row of the glyph closes.
  function automatic logic close_entry();
    entries_left = entries_left - 8'd1;
    if (entries_left != 0) begin
      dec_phase = (dec_phase == rgsr_pkg::PH_SKIP) ? rgsr_pkg::PH_RUN : rgsr_pkg::PH_SKIP;
      return 1'b0;
    end
    pen_y = pen_y + 1'b1;
    pen_x = row_x;
    rows_left = rows_left - 8'd1;
    if (rows_left == 0) begin
      dec_phase = rgsr_pkg::PH_IDLE;
      return 1'b1;
    end
    dec_phase = rgsr_pkg::PH_COUNT;
    return 1'b0;
  endfunction

  function automatic rgsr_pkg::span_t next_span(rgsr_pkg::item_t it);
    rgsr_pkg::span_t s;
    int    lo;
    int    hi;
    int    row;
    int    cl;
    int    cr;
    int    ct;
    int    cb;
    s = '0;
    if (it.glyph_start) begin
      pen_x        = {{(rgsr_pkg::COORD_BITS - 12){it.origin_x[11]}}, it.origin_x};
      pen_y        = {{(rgsr_pkg::COORD_BITS - 12){it.origin_y[11]}}, it.origin_y};
      row_x        = pen_x;
      rows_left    = '0;
      entries_left = '0;
      width_seen   = '0;
      dec_phase    = rgsr_pkg::PH_WIDTH;
    end else begin
      case (dec_phase)
        rgsr_pkg::PH_WIDTH: begin
          width_seen = it.glyph_byte;
          dec_phase = rgsr_pkg::PH_HEIGHT;
        end
        rgsr_pkg::PH_HEIGHT: begin
          rows_left = it.glyph_byte;
          dec_phase = rgsr_pkg::PH_XOFF;
        end
        rgsr_pkg::PH_XOFF: begin
          pen_x = pen_x + it.glyph_byte;
          row_x = pen_x;
          dec_phase = rgsr_pkg::PH_YOFF;
        end
        rgsr_pkg::PH_YOFF: begin
          pen_y = pen_y + it.glyph_byte;
          dec_phase = rgsr_pkg::PH_COUNT;
        end
        rgsr_pkg::PH_COUNT: begin
          entries_left = it.glyph_byte;
          dec_phase = rgsr_pkg::PH_SKIP;
        end
        rgsr_pkg::PH_SKIP: begin
          pen_x = pen_x + it.glyph_byte;
          s.glyph_done = close_entry();
        end
        rgsr_pkg::PH_RUN: begin
          // The span is clipped in plain integers; only the pen itself wraps.
          lo  = pen_x;
          hi  = lo + it.glyph_byte;
          row = pen_y;
          cl  = clip_cfg.clip_left;
          cr  = clip_cfg.clip_right;
          ct  = clip_cfg.clip_top;
          cb  = clip_cfg.clip_bottom;
          if (lo < cl) lo = cl;
          if (hi > cr) hi = cr;
          if (lo < hi && row >= ct && row < cb) begin
            s.span_valid = 1'b1;
            s.span_x     = lo[rgsr_pkg::CLIP_BITS-1:0];
            s.span_y     = row[rgsr_pkg::CLIP_BITS-1:0];
            s.span_len   = 8'(hi - lo);
            s.span_color = clip_cfg.pen_color;
          end
          pen_x = pen_x + it.glyph_byte;
          s.glyph_done = close_entry();
        end
        default: ;
      endcase
    end
    s.glyph_width = width_seen;
    return s;
  endfunction

  task automatic report(string what, longint got, longint want);
    $display("%0t ns: mismatch in %s: got %0d, expected %0d", $time, what, got, want);
    errors++;
  endtask

  task automatic check_span(rgsr_pkg::span_t got);
    rgsr_pkg::span_t want;
    if (spans_due.size() == 0) begin
      report("span beat with nothing due, span_valid", got.span_valid, 0);
      return;
    end
    want = spans_due.pop_front();
    if (got.span_valid !== want.span_valid)
      report("span_valid", got.span_valid, want.span_valid);
    if (got.span_x !== want.span_x) report("span_x", got.span_x, want.span_x);
    if (got.span_y !== want.span_y) report("span_y", got.span_y, want.span_y);
    if (got.span_len !== want.span_len) report("span_len", got.span_len, want.span_len);
    if (got.span_color !== want.span_color)
      report("span_color", got.span_color, want.span_color);
    if (got.glyph_done !== want.glyph_done)
      report("glyph_done", got.glyph_done, want.glyph_done);
    if (got.glyph_width !== want.glyph_width)
      report("glyph_width", got.glyph_width, want.glyph_width);
  endtask

  // Register writes, accepted input beats and accepted span beats, all seen at the same edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_we) apply_cfg(cfg_index, cfg_wdata);
      if (in_valid && !in_stall) spans_due.push_back(next_span(in_data));
      if (out_valid && !out_stall) check_span(out_data);
    end
  end

  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (idle_on && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 9)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  task automatic send_item(rgsr_pkg::item_t it);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_data  <= it;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic send_start(logic [11:0] x, logic [11:0] y);
    rgsr_pkg::item_t it;
    it.glyph_start = 1'b1;
    it.origin_x    = x;
    it.origin_y    = y;
    it.glyph_byte  = 8'($urandom);
    send_item(it);
  endtask

  task automatic send_byte(logic [7:0] b);
    rgsr_pkg::item_t it;
    it.glyph_start = 1'b0;
    it.origin_x    = 12'($urandom);
    it.origin_y    = 12'($urandom);
    it.glyph_byte  = b;
    send_item(it);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (spans_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write(logic [rgsr_pkg::CFG_IDX_BITS-1:0] idx,
                           logic [rgsr_pkg::CFG_DATA_BITS-1:0] data);
    cfg_index <= idx;
    cfg_wdata <= data;
    cfg_we    <= 1'b1;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_clip(logic [7:0] pen, logic [rgsr_pkg::CLIP_BITS-1:0] left,
                          logic [rgsr_pkg::CLIP_BITS-1:0] right,
                          logic [rgsr_pkg::CLIP_BITS-1:0] top,
                          logic [rgsr_pkg::CLIP_BITS-1:0] bottom);
    drain();
    // Upper data bits of the pen write carry noise that must be dropped.
    cfg_write(rgsr_pkg::CFG_PEN_COLOR, {3'($urandom), pen});
    cfg_write(rgsr_pkg::CFG_CLIP_LEFT, left);
    cfg_write(rgsr_pkg::CFG_CLIP_RIGHT, right);
    cfg_write(rgsr_pkg::CFG_CLIP_TOP, top);
    cfg_write(rgsr_pkg::CFG_CLIP_BOTTOM, bottom);
  endtask

  task automatic random_glyph(output int beats);
    logic [7:0]  rec[$];
    logic [11:0] ox;
    logic [11:0] oy;
    int          rows;
    int          cnt;
    int          keep;
    if ($urandom_range(0, 7) == 0) begin
      ox = 12'($urandom);
      oy = 12'($urandom);
    end else begin
      ox = 12'($urandom_range(0, 800)) - 12'd100;
      oy = 12'($urandom_range(0, 600)) - 12'd60;
    end
    rows = $urandom_range(1, 5);
    rec.push_back(8'($urandom));
    rec.push_back(8'(rows));
    rec.push_back(($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 40)));
    rec.push_back(($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 40)));
    repeat (rows) begin
      cnt = $urandom_range(1, 10);
      rec.push_back(8'(cnt));
      for (int e = 0; e < cnt; e++) begin
        if (e % 2 == 0)
          rec.push_back(($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 24)));
        else
          rec.push_back(($urandom_range(0, 7) == 0) ? 8'd0 : 8'($urandom));
      end
    end
    // Now and then the glyph is cut short and the next start abandons it.
    if ($urandom_range(0, 9) == 0) begin
      keep = $urandom_range(0, rec.size() - 1);
      while (rec.size() > keep) void'(rec.pop_back());
    end
    send_start(ox, oy);
    foreach (rec[k]) send_byte(rec[k]);
    beats = rec.size() + 1;
    // Stray bytes: ignored after a finished glyph, decoded after a cut one.
    if ($urandom_range(0, 4) == 0) repeat ($urandom_range(1, 3)) send_byte(8'($urandom));
  endtask

  task automatic test_idle_bytes();
    send_byte(8'h00);
    send_byte(8'hFF);
    drain();
  endtask

  task automatic test_directed_glyphs();
    // Left-clipped run, zero run, then a full-length run that finishes the glyph.
    send_start(12'(-5), 12'd2);
    send_byte(255); send_byte(2); send_byte(0); send_byte(0);
    send_byte(4); send_byte(0); send_byte(20); send_byte(0); send_byte(0);
    send_byte(2); send_byte(255); send_byte(255);
    send_byte(8'hA5);
    // Largest origin and offsets put the row below the clip rectangle.
    send_start(12'd2047, 12'd2047);
    send_byte(0); send_byte(1); send_byte(255); send_byte(255);
    send_byte(2); send_byte(0); send_byte(7);
    // Smallest origin; the row ends on a skip byte.
    send_start(12'(-2048), 12'(-2048));
    send_byte(128); send_byte(1); send_byte(0); send_byte(0);
    send_byte(1); send_byte(200);
    send_byte(8'h5A);
    drain();
  endtask

  task automatic test_clip_settings();
    int beats;
    set_clip(8'hFF, 0, 2047, 0, 2047);
    // Indexes past the register list must leave every register alone.
    for (int k = int'(rgsr_pkg::CFG_CLIP_BOTTOM) + 1; k < (1 << rgsr_pkg::CFG_IDX_BITS); k++)
      cfg_write(rgsr_pkg::CFG_IDX_BITS'(k), rgsr_pkg::CFG_DATA_BITS'($urandom));
    // Runs reaching past the right edge of the widest rectangle.
    send_start(12'd2000, 12'd2040);
    send_byte(1); send_byte(2); send_byte(0); send_byte(0);
    send_byte(2); send_byte(0); send_byte(255);
    send_byte(2); send_byte(7); send_byte(255);
    repeat (2) random_glyph(beats);
    set_clip(8'($urandom), 2047, 0, 2047, 0);
    repeat (3) random_glyph(beats);
    set_clip(8'($urandom), 320, 320, 0, 2047);
    repeat (3) random_glyph(beats);
    set_clip(8'($urandom), 300, 310, 200, 201);
    repeat (4) random_glyph(beats);
    drain();
  endtask

  task automatic test_counter_wrap();
    set_clip(8'h5A, 0, 2047, 0, 2047);
    // A height byte of zero means 256 rows.
    send_start(12'd0, 12'd0);
    send_byte(8); send_byte(0); send_byte(0); send_byte(0);
    for (int r = 0; r < 256; r++) begin
      if (r % 16 == 0) begin
        send_byte(2); send_byte(3); send_byte(5);
      end else begin
        send_byte(1); send_byte(1);
      end
    end
    // An entry count of zero means 256 entries; the pen wraps past the top of its range.
    send_start(12'd2047, 12'd100);
    send_byte(1); send_byte(1); send_byte(255); send_byte(0);
    send_byte(0);
    repeat (256) send_byte(255);
    drain();
  endtask

  task automatic test_random_streams();
    int sent;
    int beats;
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      if (ph == RANDOM_PHASES - 1) idle_on = 1'b0;
      if (ph == 1)
        set_clip(8'($urandom), 11'($urandom), 11'($urandom), 11'($urandom), 11'($urandom));
      else
        set_clip(8'($urandom), 11'($urandom_range(0, 150)), 11'($urandom_range(400, 2047)),
                 11'($urandom_range(0, 100)), 11'($urandom_range(300, 2047)));
      sent = 0;
      while (sent < ITEMS_PER_PHASE) begin
        random_glyph(beats);
        sent += beats;
      end
    end
  endtask

  initial begin
    reset_decoder();
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_we    <= 1'b0;
    cfg_index <= '0;
    cfg_wdata <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_idle_bytes();
    test_directed_glyphs();
    test_clip_settings();
    test_counter_wrap();
    test_random_streams();
    drain();
    repeat (10) @(posedge clk);
    if (errors == 0 && spans_due.size() == 0) begin
      $display("PASS rle_glyph_span_rasterizer_unit");
    end else begin
      $display("FAIL rle_glyph_span_rasterizer_unit");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("FAIL rle_glyph_span_rasterizer_unit");
    $finish;
  end

endmodule
